// File: rtl/brl_pkg.sv
// Shared types and constants for the Bresenham line rasterizer.
// No dependencies; every other file but brl_setup refers to this package by scoped names.
package brl_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int COLOR_BITS     = 4;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

endpackage

// File: rtl/brl_cmd_if.sv
// Command channel of the line rasterizer: valid/ready plus one command word.
// Depends on brl_pkg for the opcode type and color width.
interface brl_cmd_if #(
    parameter int COORD_BITS = brl_pkg::COORD_BITS_DEF
);
    logic                            valid;
    logic                            ready;
    brl_pkg::op_t                    op;
    logic [COORD_BITS-1:0]           start_x;
    logic [COORD_BITS-1:0]           start_y;
    logic [COORD_BITS-1:0]           end_x;
    logic [COORD_BITS-1:0]           end_y;
    logic [brl_pkg::COLOR_BITS-1:0]  pen_color;

    modport source (
        output valid, op, start_x, start_y, end_x, end_y, pen_color,
        input  ready
    );
    modport sink (
        input  valid, op, start_x, start_y, end_x, end_y, pen_color,
        output ready
    );
endinterface

// File: rtl/brl_pix_if.sv
// Pixel channel of the line rasterizer: valid/ready plus one pixel word.
// Depends on brl_pkg for the color width.
interface brl_pix_if #(
    parameter int COORD_BITS = brl_pkg::COORD_BITS_DEF
);
    logic                            valid;
    logic                            ready;
    logic                            valid_res;
    logic [COORD_BITS-1:0]           pixel_x;
    logic [COORD_BITS-1:0]           pixel_y;
    logic [brl_pkg::COLOR_BITS-1:0]  pixel_color;
    logic                            last;

    modport source (
        output valid, valid_res, pixel_x, pixel_y, pixel_color, last,
        input  ready
    );
    modport sink (
        input  valid, valid_res, pixel_x, pixel_y, pixel_color, last,
        output ready
    );
endinterface

// File: rtl/bresenham_line_rasterizer.sv
// Bresenham line rasterizer top level: command register, stepping logic, pixel register.
// Depends on brl_pkg, brl_cmd_if, brl_pix_if and brl_setup.
//
//   channel | modport        | word
//   --------+----------------+-------------------------------------------------
//   cmd     | brl_cmd_if.sink   | op, start_x, start_y, end_x, end_y, pen_color
//   pix     | brl_pix_if.source | valid_res, pixel_x, pixel_y, pixel_color, last
//
// One command word in, one pixel word out; a word can enter every cycle unless a stalled pix holds the pipeline.
// A word passes the setup register, then the stepping add and pixel register.
// rst_n clears the pipeline valids and the active-line flag asynchronously.
// A stalled pix holds the pixel register and back-pressures the setup register.
module bresenham_line_rasterizer #(
    parameter int COORD_BITS = brl_pkg::COORD_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    brl_cmd_if.sink   cmd,
    brl_pix_if.source pix
);
    localparam int DW = COORD_BITS + 3;
    localparam int SW = COORD_BITS + 2;
    localparam int CW = brl_pkg::COLOR_BITS;

    logic [COORD_BITS-1:0] su_major_start;
    logic [COORD_BITS-1:0] su_minor_start;
    logic [COORD_BITS-1:0] su_major_stop;
    logic [COORD_BITS-1:0] su_major_len;
    logic [COORD_BITS-1:0] su_minor_len;
    logic                  su_swapped;
    logic                  su_down;

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    brl_pkg::op_t          s1_op_reg;
    logic [COORD_BITS-1:0] s1_major_start_reg;
    logic [COORD_BITS-1:0] s1_minor_start_reg;
    logic [COORD_BITS-1:0] s1_major_stop_reg;
    logic [COORD_BITS-1:0] s1_major_len_reg;
    logic [COORD_BITS-1:0] s1_minor_len_reg;
    logic                  s1_swapped_reg;
    logic                  s1_down_reg;
    logic [CW-1:0]         s1_color_reg;

    logic                  line_active_reg;
    logic                  line_active_next;
    logic [COORD_BITS-1:0] major_pos_reg;
    logic [COORD_BITS-1:0] major_pos_next;
    logic [COORD_BITS-1:0] minor_pos_reg;
    logic [COORD_BITS-1:0] minor_pos_next;
    logic [COORD_BITS-1:0] major_end_reg;
    logic [COORD_BITS-1:0] major_end_next;
    logic signed [DW-1:0]  decision_reg;
    logic signed [DW-1:0]  decision_next;
    logic [SW-1:0]         inc_straight_reg;
    logic [SW-1:0]         inc_straight_next;
    logic signed [DW-1:0]  inc_diagonal_reg;
    logic signed [DW-1:0]  inc_diagonal_next;
    logic                  axes_swapped_reg;
    logic                  axes_swapped_next;
    logic                  minor_down_reg;
    logic                  minor_down_next;
    logic [CW-1:0]         held_color_reg;
    logic [CW-1:0]         held_color_next;

    logic                  out_valid_reg;
    logic                  res_valid_reg;
    logic                  res_valid_next;
    logic [COORD_BITS-1:0] res_x_reg;
    logic [COORD_BITS-1:0] res_x_next;
    logic [COORD_BITS-1:0] res_y_reg;
    logic [COORD_BITS-1:0] res_y_next;
    logic [CW-1:0]         res_color_reg;
    logic [CW-1:0]         res_color_next;
    logic                  res_last_reg;
    logic                  res_last_next;

    logic                  advance;
    logic                  cmd_fire;
    logic                  s2_go;
    logic signed [DW-1:0]  dmin2;
    logic signed [DW-1:0]  dmaj1;
    logic signed [DW-1:0]  dmaj2;
    logic                  emit;

    brl_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .start_x     (cmd.start_x),
        .start_y     (cmd.start_y),
        .end_x       (cmd.end_x),
        .end_y       (cmd.end_y),
        .major_start (su_major_start),
        .minor_start (su_minor_start),
        .major_stop  (su_major_stop),
        .major_len   (su_major_len),
        .minor_len   (su_minor_len),
        .swapped     (su_swapped),
        .down        (su_down)
    );

    assign advance   = !out_valid_reg || pix.ready;
    assign cmd.ready = !s1_valid_reg || advance;
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign s2_go     = s1_valid_reg && advance;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (cmd_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // stepping and line load
    always_comb
    begin
        line_active_next  = line_active_reg;
        major_pos_next    = major_pos_reg;
        minor_pos_next    = minor_pos_reg;
        major_end_next    = major_end_reg;
        decision_next     = decision_reg;
        inc_straight_next = inc_straight_reg;
        inc_diagonal_next = inc_diagonal_reg;
        axes_swapped_next = axes_swapped_reg;
        minor_down_next   = minor_down_reg;
        held_color_next   = held_color_reg;

        dmin2 = signed'({2'b00, s1_minor_len_reg, 1'b0});
        dmaj1 = signed'({3'b000, s1_major_len_reg});
        dmaj2 = signed'({2'b00, s1_major_len_reg, 1'b0});
        emit  = 1'b0;

        case (s1_op_reg)
            brl_pkg::OP_START:
            begin
                emit              = 1'b1;
                major_pos_next    = s1_major_start_reg;
                minor_pos_next    = s1_minor_start_reg;
                major_end_next    = s1_major_stop_reg;
                decision_next     = dmin2 - dmaj1;
                inc_straight_next = {1'b0, s1_minor_len_reg, 1'b0};
                inc_diagonal_next = dmin2 - dmaj2;
                axes_swapped_next = s1_swapped_reg;
                minor_down_next   = s1_down_reg;
                held_color_next   = s1_color_reg;
            end
            brl_pkg::OP_STEP:
            begin
                if (line_active_reg)
                begin
                    emit           = 1'b1;
                    major_pos_next = major_pos_reg + 1'b1;
                    if (decision_reg[DW-1])
                    begin
                        decision_next = decision_reg + signed'({1'b0, inc_straight_reg});
                    end
                    else
                    begin
                        decision_next  = decision_reg + inc_diagonal_reg;
                        minor_pos_next = minor_down_reg ? (minor_pos_reg - 1'b1)
                                                        : (minor_pos_reg + 1'b1);
                    end
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        res_valid_next = emit;
        res_x_next     = '0;
        res_y_next     = '0;
        res_color_next = '0;
        res_last_next  = 1'b0;
        if (emit)
        begin
            res_x_next       = axes_swapped_next ? minor_pos_next : major_pos_next;
            res_y_next       = axes_swapped_next ? major_pos_next : minor_pos_next;
            res_color_next   = held_color_next;
            res_last_next    = major_pos_next == major_end_next;
            line_active_next = !res_last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            line_active_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s2_go)
            begin
                line_active_reg <= line_active_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            s1_op_reg          <= cmd.op;
            s1_major_start_reg <= su_major_start;
            s1_minor_start_reg <= su_minor_start;
            s1_major_stop_reg  <= su_major_stop;
            s1_major_len_reg   <= su_major_len;
            s1_minor_len_reg   <= su_minor_len;
            s1_swapped_reg     <= su_swapped;
            s1_down_reg        <= su_down;
            s1_color_reg       <= cmd.pen_color;
        end
        if (s2_go)
        begin
            major_pos_reg    <= major_pos_next;
            minor_pos_reg    <= minor_pos_next;
            major_end_reg    <= major_end_next;
            decision_reg     <= decision_next;
            inc_straight_reg <= inc_straight_next;
            inc_diagonal_reg <= inc_diagonal_next;
            axes_swapped_reg <= axes_swapped_next;
            minor_down_reg   <= minor_down_next;
            held_color_reg   <= held_color_next;
            res_valid_reg    <= res_valid_next;
            res_x_reg        <= res_x_next;
            res_y_reg        <= res_y_next;
            res_color_reg    <= res_color_next;
            res_last_reg     <= res_last_next;
        end
    end

    assign pix.valid       = out_valid_reg;
    assign pix.valid_res   = res_valid_reg;
    assign pix.pixel_x     = res_x_reg;
    assign pix.pixel_y     = res_y_reg;
    assign pix.pixel_color = res_color_reg;
    assign pix.last        = res_last_reg;

    a_empty_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_valid_reg) |->
            (res_x_reg == '0 && res_y_reg == '0 && res_color_reg == '0 && !res_last_reg))
        else $error("empty pixel word carries nonzero fields");

    a_start_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_go && s1_op_reg == brl_pkg::OP_START) |=> res_valid_reg)
        else $error("start word produced no pixel");

    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_go && res_last_next) |=> !line_active_reg)
        else $error("line still active after last pixel");

    a_step_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_go && s1_op_reg == brl_pkg::OP_STEP && line_active_reg) |=>
            (major_pos_reg == $past(major_pos_reg) + 1'b1))
        else $error("step did not advance the major axis by one");
endmodule

// File: rtl/brl_setup.sv
// Line setup: picks the major axis and orders the endpoints along it.
// Pure combinational; no package dependencies.
module brl_setup #(
    parameter int COORD_BITS = 12
) (
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    output logic [COORD_BITS-1:0] major_start,
    output logic [COORD_BITS-1:0] minor_start,
    output logic [COORD_BITS-1:0] major_stop,
    output logic [COORD_BITS-1:0] major_len,
    output logic [COORD_BITS-1:0] minor_len,
    output logic                  swapped,
    output logic                  down
);
    logic [COORD_BITS-1:0] adx;
    logic [COORD_BITS-1:0] ady;
    logic [COORD_BITS-1:0] amaj;
    logic [COORD_BITS-1:0] amin;
    logic [COORD_BITS-1:0] bmaj;
    logic [COORD_BITS-1:0] bmin;
    logic                  flip;

    always_comb
    begin
        adx     = (start_x > end_x) ? (start_x - end_x) : (end_x - start_x);
        ady     = (start_y > end_y) ? (start_y - end_y) : (end_y - start_y);
        swapped = ady > adx;
        amaj    = swapped ? start_y : start_x;
        amin    = swapped ? start_x : start_y;
        bmaj    = swapped ? end_y   : end_x;
        bmin    = swapped ? end_x   : end_y;
        flip    = amaj > bmaj;

        major_start = flip ? bmaj : amaj;
        minor_start = flip ? bmin : amin;
        major_stop  = flip ? amaj : bmaj;
        down        = flip ? (amin < bmin) : (bmin < amin);
        major_len   = swapped ? ady : adx;
        minor_len   = swapped ? adx : ady;
    end
endmodule

// File: tb/brl_line_checker.sv
// Pixel checker for the line rasterizer: watches the command and pixel channels,
// predicts every pixel word and compares it field by field with what the block sends.
// Depends on brl_pkg, brl_cmd_if and brl_pix_if.
module brl_line_checker #(
    parameter int CB = brl_pkg::COORD_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    brl_cmd_if   cmd,
    brl_pix_if   pix,
    output int   fail_count,
    output int   pending,
    output int   checked
);

    typedef struct packed {
        logic                           valid_res;
        logic [CB-1:0]                  x;
        logic [CB-1:0]                  y;
        logic [brl_pkg::COLOR_BITS-1:0] color;
        logic                           last;
    } pixel_word_t;

    pixel_word_t expected_pixels[$];
    int errors = 0;
    int queued = 0;
    int compared = 0;

    logic                           line_on;
    logic [CB-1:0]                  maj_pos;
    logic [CB-1:0]                  min_pos;
    logic [CB-1:0]                  maj_end;
    logic signed [14:0]             decision;
    logic [13:0]                    inc_straight;
    logic signed [14:0]             inc_diagonal;
    logic                           swapped;
    logic                           min_down;
    logic [brl_pkg::COLOR_BITS-1:0] line_color;

    assign fail_count = errors;
    assign pending    = queued;
    assign checked    = compared;

    task automatic report_mismatch(input string field, input logic [15:0] got,
                                   input logic [15:0] want);
        errors++;
        $display("[%0t] pixel mismatch on %s: got %h, expected %h", $realtime, field, got, want);
    endtask

    function automatic pixel_word_t advance_line(input brl_pkg::op_t op,
            input logic [CB-1:0] ax, input logic [CB-1:0] ay,
            input logic [CB-1:0] bx, input logic [CB-1:0] by,
            input logic [brl_pkg::COLOR_BITS-1:0] color);
        pixel_word_t w;
        int adx, ady, amaj, amin, bmaj, bmin, tmp, dmaj, dmin;
        w = '0;
        if (op == brl_pkg::OP_START) begin
            adx = int'(ax) - int'(bx);
            ady = int'(ay) - int'(by);
            if (adx < 0) adx = -adx;
            if (ady < 0) ady = -ady;
            swapped = ady > adx;
            if (swapped) begin
                amaj = int'(ay); amin = int'(ax); bmaj = int'(by); bmin = int'(bx);
            end
            else begin
                amaj = int'(ax); amin = int'(ay); bmaj = int'(bx); bmin = int'(by);
            end
            if (amaj > bmaj) begin
                tmp = amaj; amaj = bmaj; bmaj = tmp;
                tmp = amin; amin = bmin; bmin = tmp;
            end
            dmaj = bmaj - amaj;
            dmin = bmin - amin;
            min_down = dmin < 0;
            if (dmin < 0) dmin = -dmin;
            decision     = 15'(2 * dmin - dmaj);
            inc_straight = 14'(2 * dmin);
            inc_diagonal = 15'(2 * (dmin - dmaj));
            maj_pos      = CB'(amaj);
            min_pos      = CB'(amin);
            maj_end      = CB'(bmaj);
            line_color   = color;
            line_on      = 1'b1;
        end
        else if (!line_on) begin
            return w;
        end
        else begin
            maj_pos = maj_pos + 1'b1;
            if (decision < 0) begin
                decision = decision + $signed({1'b0, inc_straight});
            end
            else begin
                decision = decision + inc_diagonal;
                min_pos  = min_down ? min_pos - 1'b1 : min_pos + 1'b1;
            end
        end
        w.valid_res = 1'b1;
        w.x         = swapped ? min_pos : maj_pos;
        w.y         = swapped ? maj_pos : min_pos;
        w.color     = line_color;
        w.last      = (maj_pos == maj_end);
        if (w.last) line_on = 1'b0;
        return w;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        pixel_word_t want;
        if (!rst_n) begin
            line_on      = 1'b0;
            maj_pos      = '0;
            min_pos      = '0;
            maj_end      = '0;
            decision     = '0;
            inc_straight = '0;
            inc_diagonal = '0;
            swapped      = 1'b0;
            min_down     = 1'b0;
            line_color   = '0;
            expected_pixels.delete();
            queued = 0;
        end
        else begin
            if (pix.valid && pix.ready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("word (none expected)", pix.pixel_x, '0);
                end
                else begin
                    want = expected_pixels.pop_front();
                    compared++;
                    if (pix.valid_res !== want.valid_res)
                        report_mismatch("valid_res", pix.valid_res, want.valid_res);
                    if (pix.pixel_x !== want.x)
                        report_mismatch("pixel_x", pix.pixel_x, want.x);
                    if (pix.pixel_y !== want.y)
                        report_mismatch("pixel_y", pix.pixel_y, want.y);
                    if (pix.pixel_color !== want.color)
                        report_mismatch("pixel_color", pix.pixel_color, want.color);
                    if (pix.last !== want.last)
                        report_mismatch("last", pix.last, want.last);
                end
            end
            if (cmd.valid && cmd.ready)
                expected_pixels.push_back(advance_line(cmd.op, cmd.start_x, cmd.start_y,
                                                       cmd.end_x, cmd.end_y, cmd.pen_color));
            queued = expected_pixels.size();
        end
    end

endmodule

// File: tb/tb_bresenham_line_rasterizer.sv
// Top of the line rasterizer testbench: clock, reset, command stimulus and pixel back-pressure.
// Depends on brl_pkg, brl_cmd_if, brl_pix_if, brl_line_checker and the rasterizer itself.
module tb_bresenham_line_rasterizer;

    localparam int CB = 12;

    logic clk = 1'b0;
    logic rst_n;
    bit   calm;
    int   n_starts = 0;
    int   n_steps  = 0;
    int   fail_count;
    int   pending;
    int   checked;

    brl_cmd_if #(.COORD_BITS(CB)) cmd_ch ();
    brl_pix_if #(.COORD_BITS(CB)) pix_ch ();

    bresenham_line_rasterizer #(.COORD_BITS(CB)) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .pix   (pix_ch)
    );

    brl_line_checker #(.CB(CB)) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_ch),
        .pix        (pix_ch),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_word(input brl_pkg::op_t op, input int ax, input int ay,
                             input int bx, input int by, input int color);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.op        <= op;
        cmd_ch.start_x   <= CB'(ax);
        cmd_ch.start_y   <= CB'(ay);
        cmd_ch.end_x     <= CB'(bx);
        cmd_ch.end_y     <= CB'(by);
        cmd_ch.pen_color <= 4'(color);
        do @(posedge clk); while (!cmd_ch.ready);
        if (op == brl_pkg::OP_START) n_starts++;
        else n_steps++;
    endtask

    task automatic send_step();
        send_word(brl_pkg::OP_STEP, $urandom_range(0, 4095), $urandom_range(0, 4095),
                  $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 15));
    endtask

    function automatic int near_coord(input int a, input int len);
        int off, b;
        off = int'($urandom_range(0, 2 * len)) - len;
        b = a + off;
        if (b < 0 || b > 4095) b = a - off;
        return b;
    endfunction

    task automatic random_line();
        int len, ax, ay, bx, by, dx, dy, majlen, steps, pick;
        calm = ($urandom_range(0, 4) == 0);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 10);
        ax = $urandom_range(0, 4095);
        ay = $urandom_range(0, 4095);
        if ($urandom_range(0, 15) == 0) begin
            bx = $urandom_range(0, 4095);
            by = $urandom_range(0, 4095);
        end
        else begin
            bx = near_coord(ax, len);
            by = near_coord(ay, len);
        end
        dx = (ax > bx) ? ax - bx : bx - ax;
        dy = (ay > by) ? ay - by : by - ay;
        majlen = (dy > dx) ? dy : dx;
        pick = $urandom_range(0, 5);
        if (majlen > 60)
            steps = $urandom_range(0, 6);
        else if (pick == 0)
            steps = $urandom_range(0, majlen);
        else if (pick == 1)
            steps = majlen + $urandom_range(1, 3);
        else
            steps = majlen;
        send_word(brl_pkg::OP_START, ax, ay, bx, by, $urandom_range(0, 15));
        repeat (steps) send_step();
    endtask

    initial begin
        int stall;
        pix_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                pix_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pix_ch.ready <= 1'b1;
            do @(posedge clk); while (!pix_ch.valid);
        end
    end

    initial begin
        rst_n            <= 1'b0;
        cmd_ch.valid     <= 1'b0;
        cmd_ch.op        <= brl_pkg::OP_START;
        cmd_ch.start_x   <= '0;
        cmd_ch.start_y   <= '0;
        cmd_ch.end_x     <= '0;
        cmd_ch.end_y     <= '0;
        cmd_ch.pen_color <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_step();
        send_word(brl_pkg::OP_START, 0, 0, 0, 0, 0);
        send_word(brl_pkg::OP_STEP, 4095, 4095, 4095, 4095, 15);
        send_word(brl_pkg::OP_START, 4095, 4095, 4095, 4095, 15);
        send_word(brl_pkg::OP_START, 4095, 0, 4091, 4, 10);
        repeat (4) send_step();
        send_word(brl_pkg::OP_START, 0, 4095, 2, 4088, 5);
        send_step();
        send_word(brl_pkg::OP_START, 13, 20, 10, 20, 3);
        repeat (4) send_step();
        send_word(brl_pkg::OP_START, 7, 100, 9, 106, 12);
        repeat (6) send_step();

        while (n_starts + n_steps < 445) random_line();

        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (8) @(posedge clk);

        $display("Drove %0d line starts and %0d step words, short and long lines of every slope,",
                 n_starts, n_steps);
        $display("with random gaps and stalls; %0d pixel words compared.", checked);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
